// ----- design/udbf_pkg.sv -----
// ----------------------------------------------------------------------------
// udbf_pkg
// Shared types and constants for the dual byte FIFO block (host <-> UART line).
// ----------------------------------------------------------------------------
package udbf_pkg;

    // Default ring depth in bytes
    localparam int DEFAULT_FIFO_DEPTH = 64;

    // Width of the reported fill levels
    localparam int LEVEL_W = 7;

    // Event codes
    typedef enum logic [1:0] {
        OP_HOST_READ  = 2'd0,
        OP_HOST_WRITE = 2'd1,
        OP_LINE_RECV  = 2'd2,
        OP_TX_READY   = 2'd3
    } op_t;

    // Per-ring command for one beat
    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    // Per-ring status flags
    typedef struct packed {
        logic full;
        logic empty;
    } ring_status_t;

endpackage

// ----- design/udbf_ring.sv -----
// ----------------------------------------------------------------------------
// udbf_ring
// One byte ring FIFO: synchronous memory, head/tail indexes and fill count.
// Pop data is registered and valid in the cycle after the pop.
// ----------------------------------------------------------------------------
module udbf_ring
    import udbf_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
    localparam int PTR_W  = $clog2(FIFO_DEPTH),
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ring_cmd_t         cmd,
    input  logic [7:0]        din,
    output ring_status_t      status,
    output logic [FILL_W-1:0] fill,
    output logic [7:0]        rd_data
);

    localparam logic [PTR_W-1:0]  LAST_IDX = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(FIFO_DEPTH);

    logic [7:0]        mem [FIFO_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // Index and count update; caller never pushes and pops in the same beat
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (cmd.push)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= din;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign status.full  = (fill_reg == FULL_CNT);
    assign status.empty = (fill_reg == '0);
    assign fill         = fill_reg;
    assign rd_data      = rd_data_reg;

endmodule

// ----- design/uart_dual_byte_fifo_top.sv -----
// Result timing: a result strobes on done in the cycle after its event is accepted.
// Throughput: one event per cycle; busy stays low, each event is at most a single
//   push or pop on one ring memory with a registered read.
// Reset: rst_n clears indexes, fill counts and the transmit interrupt enable;
//   ring contents are not cleared. No result is ever held back.
// ----------------------------------------------------------------------------
// uart_dual_byte_fifo_top
// Receive and transmit byte FIFOs between a host and a UART line.
// ----------------------------------------------------------------------------
module uart_dual_byte_fifo_top
    import udbf_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [7:0]         data_byte,
    output logic               done,
    output logic [7:0]         read_byte,
    output logic               read_valid,
    output logic               write_accepted,
    output logic [7:0]         line_byte,
    output logic               line_valid,
    output logic               rx_dropped,
    output logic [LEVEL_W-1:0] rx_level,
    output logic [LEVEL_W-1:0] tx_level,
    output logic               tx_irq_enabled
);

    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

    logic              accept;
    op_t               op;
    ring_cmd_t         rx_cmd, tx_cmd;
    ring_status_t      rx_stat, tx_stat;
    logic [FILL_W-1:0] rx_fill, tx_fill;
    logic [7:0]        rx_rd_data, tx_rd_data;
    logic              irq_clear;

    logic done_reg;
    logic rvalid_reg;
    logic waccept_reg;
    logic lvalid_reg;
    logic dropped_reg;
    logic irq_reg, irq_next;

    // Every beat completes in at most one memory access, so the block never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = op_t'(opcode);

    // Event decode into ring commands
    always_comb
    begin
        rx_cmd = '0;
        tx_cmd = '0;
        if (accept)
        begin
            unique case (op)
                OP_HOST_READ:  rx_cmd.pop  = !rx_stat.empty;
                OP_HOST_WRITE: tx_cmd.push = !tx_stat.full;
                OP_LINE_RECV:  rx_cmd.push = !rx_stat.full;
                OP_TX_READY:   tx_cmd.pop  = !tx_stat.empty;
                default:       rx_cmd = '0;
            endcase
        end
    end

    // Interrupt enable: set by a stored host write, cleared when tx drains
    assign irq_clear = accept && (op == OP_TX_READY)
                       && (tx_stat.empty || tx_fill == FILL_W'(1));

    always_comb
    begin
        irq_next = irq_reg;
        if (tx_cmd.push)
        begin
            irq_next = 1'b1;
        end
        else if (irq_clear)
        begin
            irq_next = 1'b0;
        end
    end

    // Result flags, registered alongside the ring update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            rvalid_reg  <= 1'b0;
            waccept_reg <= 1'b0;
            lvalid_reg  <= 1'b0;
            dropped_reg <= 1'b0;
            irq_reg     <= 1'b0;
        end
        else
        begin
            done_reg    <= accept;
            rvalid_reg  <= rx_cmd.pop;
            waccept_reg <= tx_cmd.push;
            lvalid_reg  <= tx_cmd.pop;
            dropped_reg <= accept && (op == OP_LINE_RECV) && rx_stat.full;
            irq_reg     <= irq_next;
        end
    end

    // Receive ring: line pushes, host pops
    udbf_ring #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (rx_cmd),
        .din     (data_byte),
        .status  (rx_stat),
        .fill    (rx_fill),
        .rd_data (rx_rd_data)
    );

    // Transmit ring: host pushes, transmitter pops
    udbf_ring #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_tx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tx_cmd),
        .din     (data_byte),
        .status  (tx_stat),
        .fill    (tx_fill),
        .rd_data (tx_rd_data)
    );

    // Result beat
    assign done           = done_reg;
    assign read_valid     = rvalid_reg;
    assign read_byte      = rvalid_reg ? rx_rd_data : 8'd0;
    assign write_accepted = waccept_reg;
    assign line_valid     = lvalid_reg;
    assign line_byte      = lvalid_reg ? tx_rd_data : 8'd0;
    assign rx_dropped     = dropped_reg;
    assign rx_level       = LEVEL_W'(rx_fill);
    assign tx_level       = LEVEL_W'(tx_fill);
    assign tx_irq_enabled = irq_reg;

    // Assertions
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted event produced no result beat");

    a_flags_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (read_valid || write_accepted || line_valid || rx_dropped) |-> done)
        else $error("result flag outside a result beat");

    a_irq_off_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !irq_reg |-> (tx_fill == '0))
        else $error("tx interrupt enable off while tx FIFO holds data");

    a_one_ring_op: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({rx_cmd.push, rx_cmd.pop, tx_cmd.push, tx_cmd.pop}) <= 1)
        else $error("more than one ring access in a beat");

    a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fill <= FILL_W'(FIFO_DEPTH))
        else $error("rx fill count above depth");

endmodule
